[sv/bzseg_pkg.sv]
// ============================================================================
// bzseg_pkg: shared types and constants for the bezier segment core
// Item layouts on both channels, the queue entry between front and back, and
// the fixed-point constants of the divide-by-three path.
// ============================================================================
`default_nettype none

package bzseg_pkg;

    localparam int COORD_W = 24;
    localparam int LEN_W   = 24;

    // segment verbs
    localparam logic [1:0] KIND_MOVE  = 2'd0;
    localparam logic [1:0] KIND_LINE  = 2'd1;
    localparam logic [1:0] KIND_QUAD  = 2'd2;
    localparam logic [1:0] KIND_CUBIC = 2'd3;

    // operations
    localparam logic OP_CONVERT = 1'b0;
    localparam logic OP_SPLIT   = 1'b1;

    // floor((2a + b) / 3) path: the numerator is biased by 3 * 2^COORD_W so it
    // is never negative, and the bias falls out of the low COORD_W quotient bits
    localparam int THIRD_W    = COORD_W + 3;
    localparam int THIRD_LO_W = (THIRD_W + 1) / 2;
    localparam int THIRD_HI_W = THIRD_W - THIRD_LO_W;
    localparam int PLO_W      = THIRD_LO_W + THIRD_W;
    localparam int PHI_W      = THIRD_HI_W + THIRD_W;
    localparam int PSUM_W     = 2 * THIRD_W;
    localparam logic [THIRD_W-1:0] THIRD_BIAS  = {3'b011, {COORD_W{1'b0}}};
    localparam logic [THIRD_W-1:0] THIRD_RECIP =
        THIRD_W'(((64'd1 << (THIRD_W + 1)) + 64'd2) / 64'd3);

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    typedef logic signed [COORD_W-1:0] coord_t;

    typedef struct packed {
        coord_t x;
        coord_t y;
    } point_t;

    typedef point_t [3:0] pts_t;

    typedef struct packed {
        logic             opcode;
        logic [1:0]       seg_kind;
        coord_t           pt0_x;
        coord_t           pt0_y;
        coord_t           pt1_x;
        coord_t           pt1_y;
        coord_t           pt2_x;
        coord_t           pt2_y;
        coord_t           pt3_x;
        coord_t           pt3_y;
        logic [LEN_W-1:0] seg_length;
    } in_item_t;

    typedef struct packed {
        logic [1:0]       out_kind;
        coord_t           out0_x;
        coord_t           out0_y;
        coord_t           out1_x;
        coord_t           out1_y;
        coord_t           out2_x;
        coord_t           out2_y;
        coord_t           out3_x;
        coord_t           out3_y;
        logic [LEN_W-1:0] out_length;
        logic             is_last;
    } out_item_t;

    // finished work for one input item: one or two result segments
    typedef struct packed {
        logic [1:0]       kind;
        logic             split;
        logic [LEN_W-1:0] len;
        pts_t             first;
        pts_t             second;
    } q_entry_t;

endpackage

`default_nettype wire

[sv/bzseg_front.sv]
// ============================================================================
// bzseg_front: segment front end
// Three-stage pipeline that takes segments, forms midpoints and thirds, and
// packs the one or two result segments into a queue entry.
// ============================================================================
`default_nettype none

module bzseg_front
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                seg_valid,
    output logic                     seg_ready,
    input  wire bzseg_pkg::in_item_t seg,
    output logic                     q_push,
    output bzseg_pkg::q_entry_t      q_entry,
    input  wire logic                q_full
);
    import bzseg_pkg::*;

    function automatic coord_t mid_c(coord_t a, coord_t b);
        logic [COORD_W:0] s;
        s = {a[COORD_W-1], a} + {b[COORD_W-1], b};
        return coord_t'(s[COORD_W:1]);
    endfunction

    function automatic point_t mid_pt(point_t a, point_t b);
        point_t r;
        r.x = mid_c(a.x, b.x);
        r.y = mid_c(a.y, b.y);
        return r;
    endfunction

    function automatic logic [THIRD_W-1:0] third_num(coord_t near_c, coord_t far_c);
        logic [THIRD_W-1:0] n_e;
        logic [THIRD_W-1:0] f_e;
        n_e = {{3{near_c[COORD_W-1]}}, near_c};
        f_e = {{3{far_c[COORD_W-1]}}, far_c};
        return (n_e << 1) + f_e + THIRD_BIAS;
    endfunction

    // stage valids
    logic s1_valid_reg, s1_valid_next;
    logic s2_valid_reg, s2_valid_next;
    logic s3_valid_reg, s3_valid_next;
    logic ready1, ready2, ready3;

    // stage 1
    logic               s1_op_reg;
    logic [1:0]         s1_kind_reg;
    logic [LEN_W-1:0]   s1_len_reg;
    pts_t               s1_pts_reg;
    point_t             s1_ab_reg, s1_bc_reg, s1_cd_reg;
    logic [THIRD_W-1:0] s1_num_reg [4];

    // stage 2
    logic               s2_op_reg;
    logic [1:0]         s2_kind_reg;
    logic [LEN_W-1:0]   s2_len_reg;
    pts_t               s2_pts_reg;
    point_t             s2_ab_reg, s2_bc_reg, s2_cd_reg, s2_abc_reg, s2_bcd_reg;
    logic [PLO_W-1:0]   s2_plo_reg [4];
    logic [PHI_W-1:0]   s2_phi_reg [4];

    // stage 3
    logic               s3_op_reg;
    logic [1:0]         s3_kind_reg;
    logic [LEN_W-1:0]   s3_len_reg;
    pts_t               s3_pts_reg;
    point_t             s3_ab_reg, s3_bc_reg, s3_cd_reg, s3_abc_reg, s3_bcd_reg;
    point_t             s3_abcd_reg;
    coord_t             s3_third_reg [4];

    pts_t               pts_in;
    point_t             near1, far1, near2, far2;
    logic [THIRD_W-1:0] num_in [4];
    logic [PSUM_W-1:0]  psum [4];
    point_t             t1, t2;

    // bubble-collapsing handshake down the pipe
    always_comb
    begin
        ready3        = !s3_valid_reg || !q_full;
        ready2        = !s2_valid_reg || ready3;
        ready1        = !s1_valid_reg || ready2;
        seg_ready     = ready1;
        q_push        = s3_valid_reg && !q_full;
        s1_valid_next = ready1 ? seg_valid : s1_valid_reg;
        s2_valid_next = ready2 ? s1_valid_reg : s2_valid_reg;
        s3_valid_next = ready3 ? s2_valid_reg : s3_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
            s3_valid_reg <= s3_valid_next;
        end
    end

    // stage 1 inputs: third numerators pick their points by verb
    always_comb
    begin
        pts_in[0].x = seg.pt0_x;
        pts_in[0].y = seg.pt0_y;
        pts_in[1].x = seg.pt1_x;
        pts_in[1].y = seg.pt1_y;
        pts_in[2].x = seg.pt2_x;
        pts_in[2].y = seg.pt2_y;
        pts_in[3].x = seg.pt3_x;
        pts_in[3].y = seg.pt3_y;
        // line: (2p0+p1, 2p1+p0), quadratic: (2p1+p0, 2p1+p2)
        near1 = (seg.seg_kind == KIND_LINE) ? pts_in[0] : pts_in[1];
        far1  = (seg.seg_kind == KIND_LINE) ? pts_in[1] : pts_in[0];
        near2 = pts_in[1];
        far2  = (seg.seg_kind == KIND_LINE) ? pts_in[0] : pts_in[2];
        num_in[0] = third_num(near1.x, far1.x);
        num_in[1] = third_num(near1.y, far1.y);
        num_in[2] = third_num(near2.x, far2.x);
        num_in[3] = third_num(near2.y, far2.y);
    end

    always_ff @(posedge clk)
    begin
        if (ready1)
        begin
            s1_op_reg   <= seg.opcode;
            s1_kind_reg <= seg.seg_kind;
            s1_len_reg  <= seg.seg_length;
            s1_pts_reg  <= pts_in;
            s1_ab_reg   <= mid_pt(pts_in[0], pts_in[1]);
            s1_bc_reg   <= mid_pt(pts_in[1], pts_in[2]);
            s1_cd_reg   <= mid_pt(pts_in[2], pts_in[3]);
            for (int i = 0; i < 4; i++)
            begin
                s1_num_reg[i] <= num_in[i];
            end
        end
    end

    // stage 2: reciprocal multiply split in two partial products, and second midpoint level
    always_ff @(posedge clk)
    begin
        if (ready2)
        begin
            s2_op_reg   <= s1_op_reg;
            s2_kind_reg <= s1_kind_reg;
            s2_len_reg  <= s1_len_reg;
            s2_pts_reg  <= s1_pts_reg;
            s2_ab_reg   <= s1_ab_reg;
            s2_bc_reg   <= s1_bc_reg;
            s2_cd_reg   <= s1_cd_reg;
            s2_abc_reg  <= mid_pt(s1_ab_reg, s1_bc_reg);
            s2_bcd_reg  <= mid_pt(s1_bc_reg, s1_cd_reg);
            for (int i = 0; i < 4; i++)
            begin
                s2_plo_reg[i] <= PLO_W'(s1_num_reg[i][THIRD_LO_W-1:0]) * PLO_W'(THIRD_RECIP);
                s2_phi_reg[i] <= PHI_W'(s1_num_reg[i][THIRD_W-1:THIRD_LO_W])
                                 * PHI_W'(THIRD_RECIP);
            end
        end
    end

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            psum[i] = (PSUM_W'(s2_phi_reg[i]) << THIRD_LO_W) + PSUM_W'(s2_plo_reg[i]);
        end
    end

    // stage 3: quotient and last midpoint level
    always_ff @(posedge clk)
    begin
        if (ready3)
        begin
            s3_op_reg   <= s2_op_reg;
            s3_kind_reg <= s2_kind_reg;
            s3_len_reg  <= s2_len_reg;
            s3_pts_reg  <= s2_pts_reg;
            s3_ab_reg   <= s2_ab_reg;
            s3_bc_reg   <= s2_bc_reg;
            s3_cd_reg   <= s2_cd_reg;
            s3_abc_reg  <= s2_abc_reg;
            s3_bcd_reg  <= s2_bcd_reg;
            s3_abcd_reg <= mid_pt(s2_abc_reg, s2_bcd_reg);
            for (int i = 0; i < 4; i++)
            begin
                s3_third_reg[i] <= coord_t'(psum[i][THIRD_W+1 +: COORD_W]);
            end
        end
    end

    // pack the result segments, unused points zero
    always_comb
    begin
        t1.x = s3_third_reg[0];
        t1.y = s3_third_reg[1];
        t2.x = s3_third_reg[2];
        t2.y = s3_third_reg[3];
        q_entry        = '0;
        q_entry.split  = s3_op_reg;
        if (s3_op_reg == OP_SPLIT)
        begin
            q_entry.kind = s3_kind_reg;
            q_entry.len  = s3_len_reg >> 1;
            case (s3_kind_reg)
                KIND_MOVE:
                begin
                    q_entry.first[0]  = s3_pts_reg[0];
                    q_entry.second[0] = s3_pts_reg[0];
                end
                KIND_LINE:
                begin
                    q_entry.first[0]  = s3_pts_reg[0];
                    q_entry.first[1]  = s3_ab_reg;
                    q_entry.second[0] = s3_ab_reg;
                    q_entry.second[1] = s3_pts_reg[1];
                end
                KIND_QUAD:
                begin
                    q_entry.first[0]  = s3_pts_reg[0];
                    q_entry.first[1]  = s3_ab_reg;
                    q_entry.first[2]  = s3_abc_reg;
                    q_entry.second[0] = s3_abc_reg;
                    q_entry.second[1] = s3_bc_reg;
                    q_entry.second[2] = s3_pts_reg[2];
                end
                default:
                begin
                    q_entry.first[0]  = s3_pts_reg[0];
                    q_entry.first[1]  = s3_ab_reg;
                    q_entry.first[2]  = s3_abc_reg;
                    q_entry.first[3]  = s3_abcd_reg;
                    q_entry.second[0] = s3_abcd_reg;
                    q_entry.second[1] = s3_bcd_reg;
                    q_entry.second[2] = s3_cd_reg;
                    q_entry.second[3] = s3_pts_reg[3];
                end
            endcase
        end
        else
        begin
            q_entry.kind = KIND_CUBIC;
            q_entry.len  = s3_len_reg;
            case (s3_kind_reg)
                KIND_MOVE:
                begin
                    for (int i = 0; i < 4; i++)
                    begin
                        q_entry.first[i] = s3_pts_reg[0];
                    end
                end
                KIND_LINE:
                begin
                    q_entry.first[0] = s3_pts_reg[0];
                    q_entry.first[1] = t1;
                    q_entry.first[2] = t2;
                    q_entry.first[3] = s3_pts_reg[1];
                end
                KIND_QUAD:
                begin
                    q_entry.first[0] = s3_pts_reg[0];
                    q_entry.first[1] = t1;
                    q_entry.first[2] = t2;
                    q_entry.first[3] = s3_pts_reg[2];
                end
                default:
                begin
                    q_entry.first = s3_pts_reg;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

[sv/bzseg_fifo.sv]
// ============================================================================
// bzseg_fifo: work queue
// Small queue of finished entries between the front pipeline and the
// result sequencer.
// ============================================================================
`default_nettype none

module bzseg_fifo
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                push,
    input  wire bzseg_pkg::q_entry_t push_data,
    output logic                     full,
    input  wire logic                pop,
    output logic                     empty,
    output bzseg_pkg::q_entry_t      pop_data
);
    import bzseg_pkg::*;

    q_entry_t            mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_CW-1:0] count_reg, count_next;

    always_comb
    begin
        full        = (count_reg == QUEUE_CW'(QUEUE_DEPTH));
        empty       = (count_reg == '0);
        pop_data    = mem[rd_ptr_reg];
        wr_ptr_next = push ? wr_ptr_reg + QUEUE_AW'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + QUEUE_AW'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + QUEUE_CW'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - QUEUE_CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

[sv/bzseg_back.sv]
// ============================================================================
// bzseg_back: result sequencer
// Takes queue entries and issues their one or two result segments through
// the output register.
// ============================================================================
`default_nettype none

module bzseg_back
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                q_empty,
    input  wire bzseg_pkg::q_entry_t q_head,
    output logic                     q_pop,
    output logic                     res_valid,
    input  wire logic                res_ready,
    output bzseg_pkg::out_item_t     res
);
    import bzseg_pkg::*;

    typedef enum logic [1:0]
    {
        PH_FIRST  = 2'b01,
        PH_SECOND = 2'b10
    } phase_t;

    phase_t    phase_reg, phase_next;
    logic      res_valid_reg, res_valid_next;
    out_item_t res_reg, res_next;
    logic      load, issue, last;
    pts_t      pts_sel;

    always_comb
    begin
        load  = !res_valid_reg || res_ready;
        issue = load && !q_empty;
        case (phase_reg)
            PH_FIRST:  last = !q_head.split;
            PH_SECOND: last = 1'b1;
            default:   last = 1'b1;
        endcase
        q_pop   = issue && last;
        pts_sel = (phase_reg == PH_SECOND) ? q_head.second : q_head.first;

        phase_next = phase_reg;
        if (issue)
        begin
            phase_next = last ? PH_FIRST : PH_SECOND;
        end
        res_valid_next = load ? !q_empty : res_valid_reg;

        res_next            = res_reg;
        res_next.out_kind   = q_head.kind;
        res_next.out0_x     = pts_sel[0].x;
        res_next.out0_y     = pts_sel[0].y;
        res_next.out1_x     = pts_sel[1].x;
        res_next.out1_y     = pts_sel[1].y;
        res_next.out2_x     = pts_sel[2].x;
        res_next.out2_y     = pts_sel[2].y;
        res_next.out3_x     = pts_sel[3].x;
        res_next.out3_y     = pts_sel[3].y;
        res_next.out_length = q_head.len;
        res_next.is_last    = last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_FIRST;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            res_reg <= res_next;
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule

`default_nettype wire

[sv/bezier_segment_elevate_and_split_core.sv]
// ============================================================================
// bezier_segment_elevate_and_split_core: cubic elevation and midpoint split
// Raises a path segment to a cubic, or cuts it at t = 0.5 into two halves
// with the carried length halved.
// ============================================================================
//
//  channel  | direction | handshake            | beat
//  ---------+-----------+----------------------+--------------------------------
//  seg      | in        | seg_valid/seg_ready  | one segment and its operation
//  res      | out       | res_valid/res_ready  | one result segment, is_last ends
//
// a segment passes the three front stages, the queue and the output register
// before its first result beat shows. a convert gives one result beat, a split
// two, the second in the cycle after the first is taken; the single-beat result
// register issues one beat per cycle while res_ready holds high.
// a four-entry queue parts the front pipeline from the result sequencer, so the
// input keeps flowing while a result waits on res_ready, until the queue fills.
// reset clears all valids, the queue pointers and the sequencer phase.
// ============================================================================
`default_nettype none

module bezier_segment_elevate_and_split_core
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                seg_valid,
    output logic                     seg_ready,
    input  wire bzseg_pkg::in_item_t seg,
    output logic                     res_valid,
    input  wire logic                res_ready,
    output bzseg_pkg::out_item_t     res
);
    import bzseg_pkg::*;

    logic     q_push;
    logic     q_full;
    logic     q_pop;
    logic     q_empty;
    q_entry_t q_entry;
    q_entry_t q_head;

    bzseg_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .seg_valid (seg_valid),
        .seg_ready (seg_ready),
        .seg       (seg),
        .q_push    (q_push),
        .q_entry   (q_entry),
        .q_full    (q_full)
    );

    bzseg_fifo u_fifo
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_entry),
        .full      (q_full),
        .pop       (q_pop),
        .empty     (q_empty),
        .pop_data  (q_head)
    );

    bzseg_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .q_head    (q_head),
        .q_pop     (q_pop),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    // the second half of a split follows its first half directly
    a_split_pair: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_ready && !res.is_last |=> res_valid && res.is_last)
        else $error("second half of split did not follow");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_empty)
        else $error("queue popped while empty");

    // a split pair keeps the same verb and length in both halves
    a_pair_fields: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_ready && !res.is_last |=>
            res.out_kind == $past(res.out_kind) && res.out_length == $past(res.out_length))
        else $error("split halves disagree on verb or length");

endmodule

`default_nettype wire

[dv/bezier_segment_elevate_and_split_core_test.sv]
`timescale 1ns / 100ps
// ============================================================================
// bezier_segment_elevate_and_split_core_test: self-checking bench
// Drives path segments through the core and checks every result segment
// against its own computation of cubic elevation and midpoint split. Both
// channels idle and stall at random, with one long back-pressure stretch.
// ============================================================================

import bzseg_pkg::*;

class segment_board;
    out_item_t expected_q[$];
    int        mismatches;
    longint    lo_half[2][4];
    longint    hi_half[2][4];

    function new();
        mismatches = 0;
    endfunction

    function int waiting();
        return expected_q.size();
    endfunction

    function void add_expected(out_item_t e);
        expected_q.insert(expected_q.size(), e);
    endfunction

    function longint floor_div(longint n, longint d);
        longint q;
        q = n / d;
        if ((n % d) != 0 && n < 0)
            q -= 1;
        return q;
    endfunction

    function out_item_t pack_half(logic [1:0] kind, bit upper, int npts,
                                  logic [LEN_W-1:0] len, logic last);
        out_item_t r;
        longint    v[2][4];
        for (int ax = 0; ax < 2; ax++)
            for (int i = 0; i < 4; i++)
                v[ax][i] = (i < npts) ? (upper ? hi_half[ax][i] : lo_half[ax][i]) : 0;
        r.out_kind   = kind;
        r.out0_x     = coord_t'(v[0][0]);
        r.out0_y     = coord_t'(v[1][0]);
        r.out1_x     = coord_t'(v[0][1]);
        r.out1_y     = coord_t'(v[1][1]);
        r.out2_x     = coord_t'(v[0][2]);
        r.out2_y     = coord_t'(v[1][2]);
        r.out3_x     = coord_t'(v[0][3]);
        r.out3_y     = coord_t'(v[1][3]);
        r.out_length = len;
        r.is_last    = last;
        return r;
    endfunction

    // works out the result segments of one accepted input beat
    function void note_segment(in_item_t s);
        longint p[2][4];
        longint ab, bc, cd, abc, bcd, abcd;
        int     npts;
        p[0][0] = longint'(s.pt0_x);
        p[1][0] = longint'(s.pt0_y);
        p[0][1] = longint'(s.pt1_x);
        p[1][1] = longint'(s.pt1_y);
        p[0][2] = longint'(s.pt2_x);
        p[1][2] = longint'(s.pt2_y);
        p[0][3] = longint'(s.pt3_x);
        p[1][3] = longint'(s.pt3_y);
        npts = int'(s.seg_kind) + 1;
        for (int ax = 0; ax < 2; ax++)
        begin
            for (int i = 0; i < 4; i++)
            begin
                lo_half[ax][i] = 0;
                hi_half[ax][i] = 0;
            end
            if (s.opcode == OP_CONVERT)
            begin
                case (s.seg_kind)
                    KIND_MOVE:
                    begin
                        for (int i = 0; i < 4; i++)
                            lo_half[ax][i] = p[ax][0];
                    end
                    KIND_LINE:
                    begin
                        lo_half[ax][0] = p[ax][0];
                        lo_half[ax][1] = floor_div(2 * p[ax][0] + p[ax][1], 3);
                        lo_half[ax][2] = floor_div(p[ax][0] + 2 * p[ax][1], 3);
                        lo_half[ax][3] = p[ax][1];
                    end
                    KIND_QUAD:
                    begin
                        lo_half[ax][0] = p[ax][0];
                        lo_half[ax][1] = floor_div(p[ax][0] + 2 * p[ax][1], 3);
                        lo_half[ax][2] = floor_div(p[ax][2] + 2 * p[ax][1], 3);
                        lo_half[ax][3] = p[ax][2];
                    end
                    default:
                    begin
                        for (int i = 0; i < 4; i++)
                            lo_half[ax][i] = p[ax][i];
                    end
                endcase
            end
            else
            begin
                // de casteljau at t = 0.5, each midpoint floored
                ab   = floor_div(p[ax][0] + p[ax][1], 2);
                bc   = floor_div(p[ax][1] + p[ax][2], 2);
                cd   = floor_div(p[ax][2] + p[ax][3], 2);
                abc  = floor_div(ab + bc, 2);
                bcd  = floor_div(bc + cd, 2);
                abcd = floor_div(abc + bcd, 2);
                case (s.seg_kind)
                    KIND_MOVE:
                    begin
                        lo_half[ax][0] = p[ax][0];
                        hi_half[ax][0] = p[ax][0];
                    end
                    KIND_LINE:
                    begin
                        lo_half[ax][0] = p[ax][0];
                        lo_half[ax][1] = ab;
                        hi_half[ax][0] = ab;
                        hi_half[ax][1] = p[ax][1];
                    end
                    KIND_QUAD:
                    begin
                        lo_half[ax][0] = p[ax][0];
                        lo_half[ax][1] = ab;
                        lo_half[ax][2] = abc;
                        hi_half[ax][0] = abc;
                        hi_half[ax][1] = bc;
                        hi_half[ax][2] = p[ax][2];
                    end
                    default:
                    begin
                        lo_half[ax][0] = p[ax][0];
                        lo_half[ax][1] = ab;
                        lo_half[ax][2] = abc;
                        lo_half[ax][3] = abcd;
                        hi_half[ax][0] = abcd;
                        hi_half[ax][1] = bcd;
                        hi_half[ax][2] = cd;
                        hi_half[ax][3] = p[ax][3];
                    end
                endcase
            end
        end
        if (s.opcode == OP_CONVERT)
            add_expected(pack_half(KIND_CUBIC, 1'b0, 4, s.seg_length, 1'b1));
        else
        begin
            add_expected(pack_half(s.seg_kind, 1'b0, npts, s.seg_length >> 1, 1'b0));
            add_expected(pack_half(s.seg_kind, 1'b1, npts, s.seg_length >> 1, 1'b1));
        end
    endfunction

    function void field_check(string name, logic signed [63:0] want,
                              logic signed [63:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endfunction

    function void check_result(out_item_t r);
        out_item_t e;
        if (expected_q.size() == 0)
        begin
            $error("result beat with no segment pending");
            mismatches++;
            return;
        end
        e = expected_q.pop_front();
        field_check("out_kind", e.out_kind, r.out_kind);
        field_check("out0_x", e.out0_x, r.out0_x);
        field_check("out0_y", e.out0_y, r.out0_y);
        field_check("out1_x", e.out1_x, r.out1_x);
        field_check("out1_y", e.out1_y, r.out1_y);
        field_check("out2_x", e.out2_x, r.out2_x);
        field_check("out2_y", e.out2_y, r.out2_y);
        field_check("out3_x", e.out3_x, r.out3_x);
        field_check("out3_y", e.out3_y, r.out3_y);
        field_check("out_length", e.out_length, r.out_length);
        field_check("is_last", e.is_last, r.is_last);
    endfunction
endclass

module bezier_segment_elevate_and_split_core_test;

    localparam int RANDOM_ITEMS = 1230;
    localparam int CALM_FIRST   = 400;
    localparam int CALM_LAST    = 699;
    localparam int SQUEEZE_AT   = 500;
    localparam int HOLD_CYCLES  = 400;
    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 20;

    localparam coord_t COORD_MAX = coord_t'({1'b0, {(COORD_W-1){1'b1}}});
    localparam coord_t COORD_MIN = coord_t'({1'b1, {(COORD_W-1){1'b0}}});
    localparam logic [LEN_W-1:0] LEN_MAX = '1;

    logic      clk;
    logic      rst_n;
    logic      seg_valid;
    logic      seg_ready;
    in_item_t  seg;
    logic      res_valid;
    logic      res_ready;
    out_item_t res;

    segment_board board;
    bit           gaps_on     = 1'b1;
    bit           squeeze_req = 1'b0;
    int           quiet_cycles = 0;

    bezier_segment_elevate_and_split_core dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .seg_valid (seg_valid),
        .seg_ready (seg_ready),
        .seg       (seg),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic coord_t pick_coord();
        case ($urandom_range(0, 9))
            0:       return $urandom_range(0, 1) ? COORD_MAX : COORD_MIN;
            1:       return coord_t'(int'($urandom_range(0, 8)) - 4);
            default: return coord_t'($urandom);
        endcase
    endfunction

    function automatic logic [LEN_W-1:0] pick_length();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return LEN_MAX;
            default: return LEN_W'($urandom);
        endcase
    endfunction

    function automatic in_item_t random_segment();
        in_item_t s;
        s.opcode     = $urandom_range(0, 1) ? OP_SPLIT : OP_CONVERT;
        s.seg_kind   = 2'($urandom_range(0, 3));
        s.pt0_x      = pick_coord();
        s.pt0_y      = pick_coord();
        s.pt1_x      = pick_coord();
        s.pt1_y      = pick_coord();
        s.pt2_x      = pick_coord();
        s.pt2_y      = pick_coord();
        s.pt3_x      = pick_coord();
        s.pt3_y      = pick_coord();
        s.seg_length = pick_length();
        return s;
    endfunction

    // called at a rising edge; returns at the edge that takes the beat
    task automatic offer_segment(in_item_t s);
        while (gaps_on && $urandom_range(0, 99) < 19)
        begin
            seg_valid <= 1'b0;
            @(posedge clk);
        end
        seg       <= s;
        seg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!seg_ready);
    endtask

    task automatic offer_random_as(logic op, logic [1:0] kind);
        in_item_t s;
        s          = random_segment();
        s.opcode   = op;
        s.seg_kind = kind;
        offer_segment(s);
    endtask

    // x and y alternate between the two values in opposite phase
    task automatic offer_shape(logic op, logic [1:0] kind, coord_t even_v, coord_t odd_v,
                               logic [LEN_W-1:0] len);
        in_item_t s;
        s.opcode     = op;
        s.seg_kind   = kind;
        s.pt0_x      = even_v;
        s.pt0_y      = odd_v;
        s.pt1_x      = odd_v;
        s.pt1_y      = even_v;
        s.pt2_x      = even_v;
        s.pt2_y      = odd_v;
        s.pt3_x      = odd_v;
        s.pt3_y      = even_v;
        s.seg_length = len;
        offer_segment(s);
    endtask

    // receiver: random stalls, plus one long hold-off on request
    initial
    begin
        res_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (squeeze_req)
            begin
                res_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                squeeze_req = 1'b0;
            end
            res_ready <= !(gaps_on && $urandom_range(0, 99) < 19);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (seg_valid && seg_ready)
                board.note_segment(seg);
            if (res_valid && res_ready)
                board.check_result(res);
        end
    end

    always @(posedge clk)
    begin
        if ((seg_valid && seg_ready) || (res_valid && res_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    initial
    begin
        board = new();
        rst_n     <= 1'b0;
        seg_valid <= 1'b0;
        seg       <= '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // every operation on every verb
        offer_random_as(OP_CONVERT, KIND_MOVE);
        offer_random_as(OP_CONVERT, KIND_LINE);
        offer_random_as(OP_CONVERT, KIND_QUAD);
        offer_random_as(OP_CONVERT, KIND_CUBIC);
        offer_random_as(OP_SPLIT, KIND_MOVE);
        offer_random_as(OP_SPLIT, KIND_LINE);
        offer_random_as(OP_SPLIT, KIND_QUAD);
        offer_random_as(OP_SPLIT, KIND_CUBIC);

        // full-scale coordinates and lengths
        offer_shape(OP_CONVERT, KIND_LINE, COORD_MAX, COORD_MIN, LEN_MAX);
        offer_shape(OP_CONVERT, KIND_QUAD, COORD_MIN, COORD_MAX, '0);
        offer_shape(OP_SPLIT, KIND_CUBIC, COORD_MAX, COORD_MAX, LEN_MAX);
        offer_shape(OP_SPLIT, KIND_CUBIC, COORD_MIN, COORD_MIN, 24'd1);
        offer_shape(OP_SPLIT, KIND_CUBIC, COORD_MAX, COORD_MIN, 24'd3);
        offer_shape(OP_CONVERT, KIND_CUBIC, COORD_MIN, COORD_MAX, '0);
        offer_shape(OP_CONVERT, KIND_MOVE, COORD_MAX, COORD_MIN, LEN_MAX);
        offer_shape(OP_SPLIT, KIND_MOVE, COORD_MIN, COORD_MAX, 24'd5);

        // small negatives where floor and truncation part ways
        offer_shape(OP_CONVERT, KIND_LINE, -24'sd1, 24'sd0, 24'd7);
        offer_shape(OP_CONVERT, KIND_LINE, -24'sd2, 24'sd1, 24'd8);
        offer_shape(OP_CONVERT, KIND_QUAD, -24'sd1, 24'sd1, 24'd9);
        offer_shape(OP_SPLIT, KIND_LINE, -24'sd1, 24'sd0, 24'd1);
        offer_shape(OP_SPLIT, KIND_QUAD, -24'sd3, 24'sd2, 24'd2);

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            gaps_on = !(n >= CALM_FIRST && n <= CALM_LAST);
            if (n == SQUEEZE_AT)
                squeeze_req = 1'b1;
            offer_segment(random_segment());
        end
        seg_valid <= 1'b0;
        gaps_on = 1'b1;

        do
            @(posedge clk);
        while (board.waiting() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (board.mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
